[rtl/tcraw_pkg.sv]
`timescale 1ns / 1ps
// tcraw_pkg: shared types, constants and codes of the range averaging unit
// no dependencies

package tcraw_pkg;

  localparam int SAMPLES_DEF = 8;
  localparam int SAMPLE_W    = 16;
  localparam int NUM_CH      = 3;
  localparam int QUEUE_DEPTH = 2;

  localparam int CH_LEFT  = 0;
  localparam int CH_FRONT = 1;
  localparam int CH_RIGHT = 2;

  localparam logic [SAMPLE_W-1:0] TIMEOUT_MM     = 16'd8190;
  localparam logic [SAMPLE_W-1:0] RANGE_LIMIT_MM = 16'd8000;

  localparam int CFG_W      = 13;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 4;

  localparam logic [CFG_W-1:0] LEFT_OFFSET_RST = 13'd0;
  localparam logic [CFG_W-1:0] WALL_THR_RST    = 13'd150;
  localparam logic [CFG_W-1:0] SAFETY_THR_RST  = 13'd80;

  typedef enum logic [1:0] {
    REG_LEFT_OFFSET = 2'd0,
    REG_WALL_THR    = 2'd1,
    REG_SAFETY_THR  = 2'd2
  } cfg_reg_e;

  // left_offset is two's complement
  typedef struct packed {
    logic [CFG_W-1:0] left_offset;
    logic [CFG_W-1:0] wall_threshold;
    logic [CFG_W-1:0] safety_threshold;
  } cfg_t;

  // one corrected sample per channel, indexed by CH_*
  typedef logic [NUM_CH-1:0][SAMPLE_W-1:0] sample3_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SUM,
    ST_START,
    ST_DIV,
    ST_OUT
  } back_state_t;

endpackage

[rtl/tcraw_if.sv]
`timescale 1ns / 1ps
// tcraw_in_if / tcraw_out_if: valid/ready channels of the range averaging unit
// no dependencies

interface tcraw_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] left_mm;
  logic [15:0] front_mm;
  logic [15:0] right_mm;
  logic        left_timeout;
  logic        front_timeout;
  logic        right_timeout;

  modport source (
    output valid, left_mm, front_mm, right_mm, left_timeout, front_timeout, right_timeout,
    input  ready
  );
  modport sink (
    input  valid, left_mm, front_mm, right_mm, left_timeout, front_timeout, right_timeout,
    output ready
  );
endinterface

interface tcraw_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] left_average;
  logic [15:0] front_average;
  logic [15:0] right_average;
  logic        wall_left;
  logic        wall_front;
  logic        wall_right;
  logic        left_changed;
  logic        front_changed;
  logic        right_changed;
  logic        emergency_stop;

  modport source (
    output valid, left_average, front_average, right_average, wall_left, wall_front,
           wall_right, left_changed, front_changed, right_changed, emergency_stop,
    input  ready
  );
  modport sink (
    input  valid, left_average, front_average, right_average, wall_left, wall_front,
           wall_right, left_changed, front_changed, right_changed, emergency_stop,
    output ready
  );
endinterface

[rtl/tcraw_front.sv]
`timescale 1ns / 1ps
// tcraw_front: accepts input beats, substitutes timeouts, applies left offset
// depends on tcraw_pkg and tcraw_in_if

module tcraw_front import tcraw_pkg::*; (
  tcraw_in_if.sink        in_ch,
  input  cfg_t            cfg,
  output logic            push_valid,
  input  logic            push_ready,
  output sample3_t        push_data
);

  logic [SAMPLE_W-1:0] lv;
  logic signed [17:0]  corr;

  assign in_ch.ready = push_ready;
  assign push_valid  = in_ch.valid;

  always_comb begin
    lv   = in_ch.left_timeout ? TIMEOUT_MM : in_ch.left_mm;
    corr = $signed({2'b00, lv}) +
           $signed({{5{cfg.left_offset[CFG_W-1]}}, cfg.left_offset});
    push_data[CH_FRONT] = in_ch.front_timeout ? TIMEOUT_MM : in_ch.front_mm;
    push_data[CH_RIGHT] = in_ch.right_timeout ? TIMEOUT_MM : in_ch.right_mm;
    // short readings get the offset, clamped at zero
    if (lv < RANGE_LIMIT_MM) begin
      push_data[CH_LEFT] = corr[17] ? '0 : corr[SAMPLE_W-1:0];
    end else begin
      push_data[CH_LEFT] = lv;
    end
  end

endmodule

[rtl/tcraw_fifo.sv]
`timescale 1ns / 1ps
// tcraw_fifo: short queue of corrected samples between front and back
// depends on tcraw_pkg

module tcraw_fifo import tcraw_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push_valid,
  output logic     push_ready,
  input  sample3_t push_data,
  output logic     pop_valid,
  input  logic     pop_ready,
  output sample3_t pop_data
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  sample3_t         entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

[rtl/tcraw_div.sv]
`timescale 1ns / 1ps
// tcraw_div: restoring divider, one quotient bit per cycle
// depends on tcraw_pkg

module tcraw_div import tcraw_pkg::*; #(
  parameter int DW = 19,
  parameter int CW = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [CW-1:0] divisor,
  output logic [DW-1:0] quotient,
  output logic          done
);

  localparam int STEP_W = $clog2(DW + 1);

  logic [DW-1:0]     dq_r;
  logic [CW-1:0]     rem_r;
  logic [CW-1:0]     dvs_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r, done_r;
  logic [CW:0]       trial;
  logic [CW:0]       diff;

  always_comb begin
    trial = {rem_r, dq_r[DW-1]};
    diff  = trial - {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq_r  <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      // borrow out of the trial subtract means the bit is zero
      if (trial >= {1'b0, dvs_r}) begin
        rem_r <= diff[CW-1:0];
        dq_r  <= {dq_r[DW-2:0], 1'b1};
      end else begin
        rem_r <= trial[CW-1:0];
        dq_r  <= {dq_r[DW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (busy_r) begin
      step_r <= step_r + 1'b1;
      if (step_r == STEP_W'(DW - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  assign quotient = dq_r;
  assign done     = done_r;

endmodule

[rtl/tcraw_back.sv]
`timescale 1ns / 1ps
// tcraw_back: sample rings, running sums, averaging and wall decisions
// depends on tcraw_pkg, tcraw_out_if and tcraw_div

module tcraw_back import tcraw_pkg::*; #(
  parameter int SAMPLES = SAMPLES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        q_valid,
  output logic        q_ready,
  input  sample3_t    q_data,
  tcraw_out_if.source out_ch
);

  localparam int IDX_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
  localparam int CNT_W = $clog2(SAMPLES + 1);
  localparam int SUM_W = SAMPLE_W + $clog2(SAMPLES);

  back_state_t state_r, state_nxt;

  sample3_t                           ring_mem [SAMPLES];
  sample3_t                           rd_data_r;
  sample3_t                           cur_r;
  sample3_t                           old_val;
  logic [NUM_CH-1:0][SUM_W-1:0]       sum_r;
  logic [IDX_W-1:0]                   slot_r;
  logic [CNT_W-1:0]                   count_r;
  logic                               full_r;
  logic [CNT_W-1:0]                   slot_inc;
  logic                               wrap;
  logic                               full_nxt;
  logic [NUM_CH-1:0][SUM_W-1:0]       quo;
  logic [NUM_CH-1:0]                  div_done;
  logic [NUM_CH-1:0]                  walls;
  logic                               estop;
  logic [NUM_CH-1:0]                  prev_walls_r;
  logic [NUM_CH-1:0][SAMPLE_W-1:0]    avg_r;
  logic [NUM_CH-1:0]                  walls_r;
  logic [NUM_CH-1:0]                  changed_r;
  logic                               estop_r;
  logic                               out_valid_r;
  logic                               out_free;
  logic                               mem_we;
  logic                               div_start;
  logic                               out_load;

  // ring memory, one row holds all three channels
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[slot_r] <= cur_r;
    end
    rd_data_r <= ring_mem[slot_r];
  end

  // slots not yet written are read as zero until the ring has wrapped once
  always_comb begin
    old_val  = full_r ? rd_data_r : '0;
    slot_inc = CNT_W'(slot_r) + 1'b1;
    wrap     = (slot_inc == CNT_W'(SAMPLES));
    full_nxt = full_r || wrap;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (q_valid) state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_SUM;
      ST_SUM:   state_nxt = ST_START;
      ST_START: state_nxt = ST_DIV;
      ST_DIV:   if (&div_done) state_nxt = ST_OUT;
      ST_OUT:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    q_ready   = 1'b0;
    mem_we    = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE:  q_ready   = 1'b1;
      ST_SUM:   mem_we    = 1'b1;
      ST_START: div_start = 1'b1;
      ST_OUT:   out_load  = out_free;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_valid && q_ready) begin
      cur_r <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      slot_r  <= '0;
      count_r <= '0;
      full_r  <= 1'b0;
    end else if (mem_we) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        sum_r[ch] <= sum_r[ch] - SUM_W'(old_val[ch]) + SUM_W'(cur_r[ch]);
      end
      slot_r  <= wrap ? '0 : slot_inc[IDX_W-1:0];
      full_r  <= full_nxt;
      count_r <= full_nxt ? CNT_W'(SAMPLES) : slot_inc;
    end
  end

  for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_div
    tcraw_div #(
      .DW(SUM_W),
      .CW(CNT_W)
    ) u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .start    (div_start),
      .dividend (sum_r[ch]),
      .divisor  (count_r),
      .quotient (quo[ch]),
      .done     (div_done[ch])
    );
  end

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      walls[ch] = quo[ch][SAMPLE_W-1:0] < SAMPLE_W'(cfg.wall_threshold);
    end
    estop = quo[CH_FRONT][SAMPLE_W-1:0] < SAMPLE_W'(cfg.safety_threshold);
  end

  assign out_free = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (out_load) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        avg_r[ch] <= quo[ch][SAMPLE_W-1:0];
      end
      walls_r   <= walls;
      changed_r <= walls ^ prev_walls_r;
      estop_r   <= estop;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      prev_walls_r <= '0;
    end else begin
      if (out_load) begin
        out_valid_r  <= 1'b1;
        prev_walls_r <= walls;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.left_average   = avg_r[CH_LEFT];
  assign out_ch.front_average  = avg_r[CH_FRONT];
  assign out_ch.right_average  = avg_r[CH_RIGHT];
  assign out_ch.wall_left      = walls_r[CH_LEFT];
  assign out_ch.wall_front     = walls_r[CH_FRONT];
  assign out_ch.wall_right     = walls_r[CH_RIGHT];
  assign out_ch.left_changed   = changed_r[CH_LEFT];
  assign out_ch.front_changed  = changed_r[CH_FRONT];
  assign out_ch.right_changed  = changed_r[CH_RIGHT];
  assign out_ch.emergency_stop = estop_r;

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    (CNT_W'(slot_r) < CNT_W'(SAMPLES)))
    else $error("ring slot beyond ring depth");

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_START) |-> (count_r != '0))
    else $error("divider started with zero fill count");

  a_full_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    full_r |=> full_r)
    else $error("ring full flag dropped");

  a_load_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (&div_done))
    else $error("result loaded before division finished");

endmodule

[rtl/three_channel_range_average_walls_unit.sv]
`timescale 1ns / 1ps
// three_channel_range_average_walls_unit: top level, config registers and wiring
// depends on tcraw_pkg, tcraw_if, tcraw_front, tcraw_fifo and tcraw_back
//
// usage
// - in_ch carries one beat of three range readings (left, front, right) with
//   a timeout flag each; out_ch returns one beat of three averages, wall
//   flags, wall change flags and the emergency stop flag for every input beat
// - the apb-style port (psel, penable, pwrite, paddr, pwdata) holds
//   left_offset at 0x0, wall_threshold at 0x4 and front_safety_threshold at
//   0x8; write it only while the unit is idle; pready is tied high
// - the front stage cleans each reading in the accepting cycle and drops it
//   into a two-deep queue, so inputs keep being taken while the back end works
// - the back end takes one beat per pass: ring read, sum update, then three
//   restoring dividers run in parallel, one quotient bit per cycle
// - the time per beat in the back end is set by the bit-serial divide of the
//   running sum by the fill count; the back end takes no new beat until the
//   result of the last one is loaded into the output register
// - a finished result sits in the output register until taken; a stalled
//   receiver holds the back end but the queue still fills
// - reset clears sums, fill state, previous wall flags and config registers;
//   ring entries are never cleared, unwritten slots are masked until the ring
//   has wrapped once

module three_channel_range_average_walls_unit import tcraw_pkg::*; #(
  parameter int SAMPLES = SAMPLES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  tcraw_in_if.sink              in_ch,
  tcraw_out_if.source           out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t     cfg_r;
  cfg_reg_e reg_sel;
  logic     cfg_wr;
  logic     push_valid, push_ready;
  sample3_t push_data;
  logic     q_valid, q_ready;
  sample3_t q_data;

  // register index from the word address
  assign reg_sel = cfg_reg_e'(paddr[3:2]);
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.left_offset      <= LEFT_OFFSET_RST;
      cfg_r.wall_threshold   <= WALL_THR_RST;
      cfg_r.safety_threshold <= SAFETY_THR_RST;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_LEFT_OFFSET: cfg_r.left_offset      <= pwdata[CFG_W-1:0];
        REG_WALL_THR:    cfg_r.wall_threshold   <= pwdata[CFG_W-1:0];
        REG_SAFETY_THR:  cfg_r.safety_threshold <= pwdata[CFG_W-1:0];
        default:         ;
      endcase
    end
  end

  // offset reads back sign-extended, unmapped addresses read zero
  always_comb begin
    unique case (reg_sel)
      REG_LEFT_OFFSET: prdata = {{(APB_DATA_W-CFG_W){cfg_r.left_offset[CFG_W-1]}},
                                 cfg_r.left_offset};
      REG_WALL_THR:    prdata = APB_DATA_W'(cfg_r.wall_threshold);
      REG_SAFETY_THR:  prdata = APB_DATA_W'(cfg_r.safety_threshold);
      default:         prdata = '0;
    endcase
  end

  tcraw_front u_front (
    .in_ch      (in_ch),
    .cfg        (cfg_r),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  tcraw_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  tcraw_back #(
    .SAMPLES(SAMPLES)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_data  (q_data),
    .out_ch  (out_ch)
  );

endmodule
